// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpe_pkg
// Types, codes and Kleene logic functions of the postfix logic evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

    localparam int OP_W       = 3;
    localparam int PID_W      = 6;
    localparam int PVAL_W     = 2;
    localparam int PCNT_W     = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;
    localparam int STATUS_W   = 2;

    typedef enum logic [1:0] {
        V_ZERO = 2'd0,
        V_ONE  = 2'd1,
        V_UNK  = 2'd2
    } t_val;

    typedef enum logic [OP_W-1:0] {
        OP_PORT   = 3'd0,
        OP_CONST0 = 3'd1,
        OP_CONST1 = 3'd2,
        OP_NOT    = 3'd3,
        OP_AND    = 3'd4,
        OP_OR     = 3'd5,
        OP_XOR    = 3'd6,
        OP_WRITE  = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DEPTH    = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Registered port table read, aligned with the item in the input register
    typedef struct packed {
        logic hit;
        t_val value;
    } t_port_rd;

    // Item handed to the stack unit in the cycle it executes
    typedef struct packed {
        logic    fire;
        t_opcode opcode;
        logic    last;
        t_val    port_val;
    } t_exec_cmd;

    typedef struct packed {
        logic    valid;
        logic    value;
        t_status status;
    } t_result;

    // Unsigned port value code: 0 and 1 map through, anything else is unknown
    function automatic t_val decode_pval(logic [PVAL_W-1:0] pv);
        t_val v;
        unique case (pv)
            2'b00:   v = V_ZERO;
            2'b01:   v = V_ONE;
            default: v = V_UNK;
        endcase
        return v;
    endfunction

    function automatic t_val k_not(t_val a);
        t_val v;
        unique case (a)
            V_ZERO:  v = V_ONE;
            V_ONE:   v = V_ZERO;
            default: v = V_UNK;
        endcase
        return v;
    endfunction

    function automatic t_val k_and(t_val a, t_val b);
        t_val v;
        if (a == V_ZERO || b == V_ZERO) begin
            v = V_ZERO;
        end else if (a == V_ONE && b == V_ONE) begin
            v = V_ONE;
        end else begin
            v = V_UNK;
        end
        return v;
    endfunction

    function automatic t_val k_or(t_val a, t_val b);
        t_val v;
        if (a == V_ONE || b == V_ONE) begin
            v = V_ONE;
        end else if (a == V_ZERO && b == V_ZERO) begin
            v = V_ZERO;
        end else begin
            v = V_UNK;
        end
        return v;
    endfunction

    function automatic t_val k_xor(t_val a, t_val b);
        t_val v;
        if ((a != V_ZERO && a != V_ONE) || (b != V_ZERO && b != V_ONE)) begin
            v = V_UNK;
        end else if (a == b) begin
            v = V_ZERO;
        end else begin
            v = V_ONE;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/ternary_postfix_logic_evaluator.sv =====
// ----------------------------------------------------------------------------
// ternary_postfix_logic_evaluator
// Three-valued postfix logic evaluator: at most one stack operation per word, one
// result word per expression.
//
//  channel | direction | tdata / data        | tuser     | tlast
//  --------+-----------+---------------------+-----------+------------------
//  s       | in        | port_id, port_value | opcode    | last of expression
//  m       | out       | result_value        | status    | -
//  cfg     | in        | port_count          | -         | -
//
// One word per cycle sustained unless a last word waits on a stalled output; a
// word is registered in the input register at its handshake and executes there,
// and a last word's result is then registered in the output register.
// The port table is written and read at the input handshake; its read data is
// registered alongside the word. Reset is synchronous and clears the stack,
// the port table valid bits and the output. A stalled output holds only a word
// marked last; other words keep flowing under it.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_postfix_logic_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_PORTS   = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [tpe_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [5:0] port_id, [7:6] port_value
    input  wire logic [tpe_pkg::OP_W-1:0]       i_s_tuser,   // [2:0] opcode
    input  wire logic                           i_s_tlast,
    // master stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [tpe_pkg::OUT_DATA_W-1:0]      o_m_tdata,   // [0] result_value, rest zero
    output logic [tpe_pkg::STATUS_W-1:0]        o_m_tuser,   // [1:0] status
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tpe_pkg::PCNT_W-1:0]     i_cfg_data
);

    logic                        accept;
    logic                        fire;
    logic                        out_free;
    logic                        r_in_valid;
    tpe_pkg::t_opcode            r_in_op;
    logic [tpe_pkg::PID_W-1:0]   r_in_pid;
    logic                        r_in_last;
    logic [tpe_pkg::PCNT_W-1:0]  r_port_count;
    logic                        r_out_valid;
    logic                        r_out_value;
    tpe_pkg::t_status            r_out_status;
    tpe_pkg::t_opcode            in_op;
    tpe_pkg::t_port_rd           port_rd;
    tpe_pkg::t_exec_cmd          cmd;
    tpe_pkg::t_result            res;

    assign in_op      = tpe_pkg::t_opcode'(i_s_tuser);
    assign out_free   = !r_out_valid || i_m_tready;
    // Only a last word needs room in the output register
    assign fire       = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || fire;
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count <= '0;
        end else if (i_cfg_valid) begin
            r_port_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op   <= in_op;
            r_in_pid  <= i_s_tdata[tpe_pkg::PID_W-1:0];
            r_in_last <= i_s_tlast;
        end
    end

    tpe_port_table #(
        .MAX_PORTS (MAX_PORTS)
    ) u_port_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (accept && (in_op == tpe_pkg::OP_WRITE)),
        .i_port_id (i_s_tdata[tpe_pkg::PID_W-1:0]),
        .i_wr_val  (tpe_pkg::decode_pval(
                        i_s_tdata[tpe_pkg::PID_W +: tpe_pkg::PVAL_W])),
        .o_rd      (port_rd)
    );

    always_comb begin
        cmd          = '0;
        cmd.fire     = fire;
        cmd.opcode   = r_in_op;
        cmd.last     = r_in_last;
        cmd.port_val = tpe_pkg::V_UNK;
        if (port_rd.hit && ({1'b0, r_in_pid} < r_port_count)) begin
            cmd.port_val = port_rd.value;
        end
    end

    tpe_stack_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_value  <= res.value;
            r_out_status <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tpe_pkg::OUT_DATA_W-1){1'b0}}, r_out_value};
    assign o_m_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== src/tpe_port_table.sv =====
// ----------------------------------------------------------------------------
// tpe_port_table
// Port value memory with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_port_table #(
    parameter int MAX_PORTS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic                      i_wr_en,
    input  wire logic [tpe_pkg::PID_W-1:0] i_port_id,
    input  wire tpe_pkg::t_val             i_wr_val,
    output tpe_pkg::t_port_rd              o_rd
);

    localparam int PT_DEPTH = (MAX_PORTS < (1 << tpe_pkg::PID_W)) ?
                              MAX_PORTS : (1 << tpe_pkg::PID_W);
    localparam int AW       = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int NE       = 1 << AW;

    tpe_pkg::t_val r_mem [NE];
    logic [NE-1:0] r_vld;
    logic [NE-1:0] n_vld;
    tpe_pkg::t_val r_rd_value;
    logic          r_rd_hit;
    logic [AW-1:0] addr;
    logic          in_range;

    assign addr     = i_port_id[AW-1:0];
    assign in_range = (32'(i_port_id) < 32'(PT_DEPTH));

    always_comb begin
        n_vld = r_vld;
        if (i_wr_en && in_range) begin
            n_vld[addr] = 1'b1;
        end
    end

    // Entries never written read as unknown through their clear valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_mem[addr] <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_value <= r_mem[addr];
            r_rd_hit   <= in_range && r_vld[addr];
        end
    end

    assign o_rd.hit   = r_rd_hit;
    assign o_rd.value = r_rd_value;

endmodule

`default_nettype wire

// ===== src/tpe_stack_exec.sv =====
// ----------------------------------------------------------------------------
// tpe_stack_exec
// Value stack held as a shift register, top at entry 0, plus the Kleene
// operator and the end-of-expression status.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_stack_exec #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tpe_pkg::t_exec_cmd i_cmd,
    output tpe_pkg::t_result        o_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    tpe_pkg::t_val r_stk [STACK_DEPTH];
    tpe_pkg::t_val n_stk [STACK_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_ovf;
    logic          n_ovf;
    tpe_pkg::t_val top_v;
    tpe_pkg::t_val sec_v;
    tpe_pkg::t_val push_v;
    tpe_pkg::t_val bin_v;
    logic          do_push;
    logic          do_bin;

    // Empty slots pop as unknown
    assign top_v = (r_cnt != '0) ? r_stk[0] : tpe_pkg::V_UNK;
    assign sec_v = (r_cnt > CW'(1)) ? r_stk[1] : tpe_pkg::V_UNK;

    always_comb begin
        n_stk   = r_stk;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        do_push = 1'b0;
        do_bin  = 1'b0;
        push_v  = tpe_pkg::V_UNK;
        bin_v   = tpe_pkg::V_UNK;
        o_res   = '0;

        unique case (i_cmd.opcode)
            tpe_pkg::OP_PORT: begin
                do_push = 1'b1;
                push_v  = i_cmd.port_val;
            end
            tpe_pkg::OP_CONST0: begin
                do_push = 1'b1;
                push_v  = tpe_pkg::V_ZERO;
            end
            tpe_pkg::OP_CONST1: begin
                do_push = 1'b1;
                push_v  = tpe_pkg::V_ONE;
            end
            tpe_pkg::OP_NOT: begin
                n_stk[0] = tpe_pkg::k_not(top_v);
                if (r_cnt == '0) begin
                    n_cnt = CW'(1);
                end
            end
            tpe_pkg::OP_AND: begin
                do_bin = 1'b1;
                bin_v  = tpe_pkg::k_and(sec_v, top_v);
            end
            tpe_pkg::OP_OR: begin
                do_bin = 1'b1;
                bin_v  = tpe_pkg::k_or(sec_v, top_v);
            end
            tpe_pkg::OP_XOR: begin
                do_bin = 1'b1;
                bin_v  = tpe_pkg::k_xor(sec_v, top_v);
            end
            tpe_pkg::OP_WRITE: begin
            end
            default: begin
            end
        endcase

        // Pop two, push one: shift the rest up by one
        if (do_bin) begin
            n_stk[0] = bin_v;
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                n_stk[i] = r_stk[i+1];
            end
            n_cnt = (r_cnt > CW'(1)) ? r_cnt - CW'(1) : CW'(1);
        end

        // Drop the push on a full stack and flag it
        if (do_push) begin
            if (r_cnt == CW'(STACK_DEPTH)) begin
                n_ovf = 1'b1;
            end else begin
                n_stk[0] = push_v;
                for (int i = 1; i < STACK_DEPTH; i++) begin
                    n_stk[i] = r_stk[i-1];
                end
                n_cnt = r_cnt + CW'(1);
            end
        end

        if (i_cmd.last) begin
            o_res.valid = i_cmd.fire;
            priority if (n_ovf) begin
                o_res.status = tpe_pkg::ST_OVERFLOW;
            end else if (n_cnt != CW'(1)) begin
                o_res.status = tpe_pkg::ST_DEPTH;
            end else if (n_stk[0] != tpe_pkg::V_ZERO && n_stk[0] != tpe_pkg::V_ONE) begin
                o_res.status = tpe_pkg::ST_UNKNOWN;
            end else begin
                o_res.status = tpe_pkg::ST_OK;
                o_res.value  = (n_stk[0] == tpe_pkg::V_ONE);
            end
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.fire) begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_stk <= n_stk;
        end
    end

endmodule

`default_nettype wire

// ===== src/tpe_checker.sv =====
// ----------------------------------------------------------------------------
// tpe_checker
// Port-level checks of the postfix logic evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpe_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [tpe_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic [tpe_pkg::STATUS_W-1:0]   o_m_tuser
);

    // Stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result word changed while stalled")

    // Result word leaves only through a handshake
    `ASSERT_IMPLY(a_out_drop, i_clk, i_rst_n, $fell(o_m_tvalid), $past(i_m_tready), "result word dropped without handshake")

    // Value is zero unless the status is ok
    `ASSERT_IMPLY(a_value_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != tpe_pkg::ST_OK), o_m_tdata == '0, "result value set on error status")

    // With room at the output the input side never stalls
    `ASSERT_IMPLY(a_no_stall, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready, "input stalled with free output")

endmodule

bind ternary_postfix_logic_evaluator tpe_checker u_tpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
